// ----- sv/pressure_temp_compensation_defines.svh -----
// Assertion macros shared by the compensation block.
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pressure_temp_compensation: property violated");

// Next-cycle implication, disabled during reset.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pressure_temp_compensation: property violated");

`endif

// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants shared by the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

  typedef enum logic [2:0] {
    REG_MODEL,
    REG_SENS,
    REG_OFF,
    REG_TCS,
    REG_TCO,
    REG_TREF,
    REG_TEMPSENS
  } reg_idx_t;

  typedef struct packed {
    logic        sensor_model;
    logic [15:0] coef_sens;
    logic [15:0] coef_off;
    logic [15:0] coef_tcs;
    logic [15:0] coef_tco;
    logic [15:0] coef_tref;
    logic [15:0] coef_tempsens;
  } cfg_t;

  // Item as classified by the front end.
  typedef struct packed {
    logic               low_range;
    logic        [23:0] d1;
    logic signed [24:0] dt;
  } item_t;

  typedef struct packed {
    logic signed [18:0] temp_centi;
    logic signed [17:0] pressure_mbar;
    logic               pressure_saturated;
  } result_t;

  localparam logic signed [20:0] TEMP_NOMINAL  = 21'sd2000;
  localparam logic signed [20:0] VERYCOLD_OFS  = 21'sd3500;
  localparam logic signed [19:0] VERYCOLD_DEV  = -20'sd3500;
  // Reciprocals scaled by 2^31, rounded up; exact for dividends below 2^24.
  localparam logic [27:0]        RECIP_10      = 28'd214748365;
  localparam logic [27:0]        RECIP_100     = 28'd21474837;
  localparam int                 RECIP_SHIFT   = 31;
  localparam logic [23:0]        MAG_CLAMP     = 24'hFFFFFF;
  localparam logic [20:0]        PMAX_MAG      = 21'd131071;
  localparam logic [20:0]        PMIN_MAG      = 21'd131072;

endpackage

// ----- sv/ptc_fifo.sv -----
// ----------------------------------------------------------------------------
// ptc_fifo
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module ptc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ----- sv/ptc_front.sv -----
// ----------------------------------------------------------------------------
// ptc_front
// Accepts conversion pairs, forms dT and the range tag, and queues them.
// ----------------------------------------------------------------------------
module ptc_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [23:0]        pressure_raw,
  input  logic [23:0]        temp_raw,
  output logic               full,
  input  ptc_pkg::cfg_t      cfg,
  input  logic               issue,
  output logic               avail,
  output ptc_pkg::item_t     item
);
  ptc_pkg::item_t in_item;
  logic           q_empty;
  logic [$bits(ptc_pkg::item_t)-1:0] q_dout;

  // dT = D2 - C5 * 256
  always_comb begin
    in_item.low_range = cfg.sensor_model;
    in_item.d1        = pressure_raw;
    in_item.dt        = $signed({1'b0, temp_raw}) - $signed({1'b0, cfg.coef_tref, 8'd0});
  end

  ptc_fifo #(
    .WIDTH($bits(ptc_pkg::item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (in_item),
    .full (full),
    .pop  (issue),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign avail = !q_empty;
  assign item  = ptc_pkg::item_t'(q_dout);

endmodule

// ----- sv/ptc_back.sv -----
// ----------------------------------------------------------------------------
// ptc_back
// Nine-stage compensation pipeline: first order, second order, pressure.
// ----------------------------------------------------------------------------
module ptc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               issue,
  input  ptc_pkg::item_t     item,
  input  ptc_pkg::cfg_t      cfg,
  output logic               res_valid,
  output ptc_pkg::result_t   res
);
  logic [8:0] vld;

  // stage 1: products of dT
  logic               s1_lr;
  logic        [23:0] s1_d1;
  logic signed [41:0] s1_m1, s1_m2, s1_m3;
  logic        [47:0] s1_m4;
  logic signed [49:0] sq_dt;

  // stage 2: first-order values
  logic               s2_lr;
  logic        [23:0] s2_d1;
  logic signed [19:0] s2_q;
  logic signed [39:0] s2_sens, s2_off;
  logic        [47:0] s2_m4;
  logic signed [41:0] m1_t, m2_t7, m2_t8, m3_t6, m3_t7;

  // stage 3: squares and temperature correction
  logic               s3_lr, s3_cold, s3_vcold;
  logic        [23:0] s3_d1;
  logic signed [39:0] s3_sens, s3_off;
  logic        [39:0] s3_dev2, s3_v2;
  logic signed [18:0] s3_temp;
  logic signed [39:0] dev2_c;
  logic signed [20:0] v_c;
  logic signed [41:0] v2_c;
  logic        [51:0] ti11;
  logic        [49:0] ti3;
  logic        [16:0] ti_c;
  logic signed [20:0] temp_c;

  // stage 4: corrected SENS and OFF
  logic               s4_lr;
  logic        [23:0] s4_d1;
  logic signed [39:0] s4_sens, s4_off;
  logic signed [18:0] s4_temp;
  logic        [45:0] offi, sensi;
  logic signed [45:0] sens_c, off_c;

  // stage 5: partial products of D1 * SENS
  logic               s5_lr;
  logic        [42:0] s5_pl;
  logic signed [45:0] s5_ph;
  logic signed [39:0] s5_off;
  logic signed [18:0] s5_temp;

  // stage 6: full product
  logic               s6_lr;
  logic signed [65:0] s6_prod;
  logic signed [39:0] s6_off;
  logic signed [18:0] s6_temp;

  // stage 7: D1*SENS/2^21 - OFF
  logic               s7_lr;
  logic signed [43:0] s7_x;
  logic signed [18:0] s7_temp;
  logic signed [65:0] prod_t;

  // stage 8: scaled magnitude
  logic               s8_lr, s8_neg;
  logic        [23:0] s8_n;
  logic signed [18:0] s8_temp;
  logic signed [43:0] y13, y15, y_c;
  logic        [43:0] mag_c;

  // stage 9: decimal divide
  logic               s9_neg;
  logic        [20:0] s9_q;
  logic signed [18:0] s9_temp;
  logic        [51:0] qp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[7:0], issue};
    end
  end

  assign sq_dt = item.dt * item.dt;

  always_ff @(posedge clk) begin
    s1_lr <= item.low_range;
    s1_d1 <= item.d1;
    s1_m1 <= item.dt * $signed({1'b0, cfg.coef_tempsens});
    s1_m2 <= item.dt * $signed({1'b0, cfg.coef_tcs});
    s1_m3 <= item.dt * $signed({1'b0, cfg.coef_tco});
    s1_m4 <= sq_dt[47:0];
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    m1_t  = (s1_m1 + (s1_m1[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    m2_t7 = (s1_m2 + (s1_m2[41] ? 42'sd127 : 42'sd0)) >>> 7;
    m2_t8 = (s1_m2 + (s1_m2[41] ? 42'sd255 : 42'sd0)) >>> 8;
    m3_t6 = (s1_m3 + (s1_m3[41] ? 42'sd63 : 42'sd0)) >>> 6;
    m3_t7 = (s1_m3 + (s1_m3[41] ? 42'sd127 : 42'sd0)) >>> 7;
  end

  always_ff @(posedge clk) begin
    s2_lr <= s1_lr;
    s2_d1 <= s1_d1;
    s2_q  <= m1_t[19:0];
    s2_m4 <= s1_m4;
    if (s1_lr) begin
      s2_sens <= $signed({8'd0, cfg.coef_sens, 16'd0}) + m2_t7[39:0];
      s2_off  <= $signed({7'd0, cfg.coef_off, 17'd0}) + m3_t6[39:0];
    end else begin
      s2_sens <= $signed({9'd0, cfg.coef_sens, 15'd0}) + m2_t8[39:0];
      s2_off  <= $signed({8'd0, cfg.coef_off, 16'd0}) + m3_t7[39:0];
    end
  end

  always_comb begin
    dev2_c = s2_q * s2_q;
    v_c    = {s2_q[19], s2_q} + ptc_pkg::VERYCOLD_OFS;
    v2_c   = v_c * v_c;
    ti11   = {s2_m4, 3'd0} + {3'd0, s2_m4, 1'b0} + {4'd0, s2_m4};
    ti3    = {1'b0, s2_m4, 1'b0} + {2'd0, s2_m4};
    ti_c   = '0;
    if (s2_q[19]) begin
      ti_c = s2_lr ? ti11[51:35] : ti3[49:33];
    end else if (!s2_lr) begin
      ti_c = {5'd0, s2_m4[47:36]};
    end
    temp_c = ptc_pkg::TEMP_NOMINAL + {s2_q[19], s2_q} - $signed({4'd0, ti_c});
  end

  always_ff @(posedge clk) begin
    s3_lr    <= s2_lr;
    s3_d1    <= s2_d1;
    s3_sens  <= s2_sens;
    s3_off   <= s2_off;
    s3_cold  <= s2_q[19];
    s3_vcold <= (s2_q < ptc_pkg::VERYCOLD_DEV);
    s3_dev2  <= dev2_c;
    s3_v2    <= v2_c[39:0];
    s3_temp  <= temp_c[18:0];
  end

  always_comb begin
    offi  = '0;
    sensi = '0;
    if (s3_lr) begin
      if (s3_cold) begin
        offi  = ({1'b0, s3_dev2, 5'd0} - {6'd0, s3_dev2}) >> 3;
        sensi = ({s3_dev2, 6'd0} - {6'd0, s3_dev2}) >> 5;
      end
    end else if (s3_cold) begin
      offi  = ({5'd0, s3_dev2, 1'b0} + {6'd0, s3_dev2}) >> 1;
      sensi = ({4'd0, s3_dev2, 2'd0} + {6'd0, s3_dev2}) >> 3;
      if (s3_vcold) begin
        offi  = offi + ({3'd0, s3_v2, 3'd0} - {6'd0, s3_v2});
        sensi = sensi + {4'd0, s3_v2, 2'd0};
      end
    end else begin
      offi = {6'd0, s3_dev2} >> 4;
    end
    sens_c = {{6{s3_sens[39]}}, s3_sens} - $signed(sensi);
    off_c  = {{6{s3_off[39]}}, s3_off} - $signed(offi);
  end

  always_ff @(posedge clk) begin
    s4_lr   <= s3_lr;
    s4_d1   <= s3_d1;
    s4_sens <= sens_c[39:0];
    s4_off  <= off_c[39:0];
    s4_temp <= s3_temp;
  end

  // split SENS so that each multiplier stays narrow
  always_ff @(posedge clk) begin
    s5_lr   <= s4_lr;
    s5_pl   <= s4_d1 * s4_sens[18:0];
    s5_ph   <= $signed({1'b0, s4_d1}) * $signed(s4_sens[39:19]);
    s5_off  <= s4_off;
    s5_temp <= s4_temp;
  end

  always_ff @(posedge clk) begin
    s6_lr   <= s5_lr;
    s6_prod <= $signed({s5_ph[45], s5_ph, 19'd0}) + $signed({23'd0, s5_pl});
    s6_off  <= s5_off;
    s6_temp <= s5_temp;
  end

  assign prod_t = (s6_prod + (s6_prod[65] ? 66'sd2097151 : 66'sd0)) >>> 21;

  always_ff @(posedge clk) begin
    s7_lr   <= s6_lr;
    s7_x    <= prod_t[43:0] - {{4{s6_off[39]}}, s6_off};
    s7_temp <= s6_temp;
  end

  always_comb begin
    y13   = (s7_x + (s7_x[43] ? 44'sd8191 : 44'sd0)) >>> 13;
    y15   = (s7_x + (s7_x[43] ? 44'sd32767 : 44'sd0)) >>> 15;
    y_c   = s7_lr ? y15 : y13;
    mag_c = y_c[43] ? 44'(-y_c) : 44'(y_c);
  end

  // clamp the magnitude: anything this large saturates anyway
  always_ff @(posedge clk) begin
    s8_lr   <= s7_lr;
    s8_neg  <= y_c[43];
    s8_n    <= (mag_c > {20'd0, ptc_pkg::MAG_CLAMP}) ? ptc_pkg::MAG_CLAMP : mag_c[23:0];
    s8_temp <= s7_temp;
  end

  assign qp_c = s8_n * (s8_lr ? ptc_pkg::RECIP_100 : ptc_pkg::RECIP_10);

  always_ff @(posedge clk) begin
    s9_neg  <= s8_neg;
    s9_q    <= qp_c[ptc_pkg::RECIP_SHIFT +: 21];
    s9_temp <= s8_temp;
  end

  always_comb begin
    res.temp_centi         = s9_temp;
    res.pressure_saturated = 1'b0;
    if (!s9_neg && (s9_q > ptc_pkg::PMAX_MAG)) begin
      res.pressure_mbar      = 18'sd131071;
      res.pressure_saturated = 1'b1;
    end else if (s9_neg && (s9_q > ptc_pkg::PMIN_MAG)) begin
      res.pressure_mbar      = -18'sd131072;
      res.pressure_saturated = 1'b1;
    end else if (s9_neg) begin
      res.pressure_mbar = 18'(-$signed({1'b0, s9_q}));
    end else begin
      res.pressure_mbar = s9_q[17:0];
    end
  end

  assign res_valid = vld[8];

endmodule

// ----- sv/pressure_temp_compensation.sv -----
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Second-order pressure and temperature compensation of raw sensor pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present pressure_raw (D1) and temp_raw (D2) with push;
//   the item is taken on a clock edge where push is high and full is low.
//   Result channel: while empty is low, temp_centi, pressure_mbar and
//   pressure_saturated show the oldest result; pop takes it.
//   Configuration: wr_en with wr_index and wr_data writes one calibration
//   register per cycle; write only while no items are in flight.
//   Path: an item passes through the front queue, then the nine pipeline
//   stages, the last of which writes the result queue.
//   Throughput: one item per cycle while the result queue has room, set by
//   the fully pipelined back end.
//   Stall: the back end issues only when the result queue has room for
//   every item in flight, so a stalled receiver first fills the result
//   queue, then the front queue, and then raises full.
//   Reset: rst clears the calibration registers, pend and the valid pipeline to 0 and empties both queues.
// ----------------------------------------------------------------------------
`include "pressure_temp_compensation_defines.svh"

module pressure_temp_compensation #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [23:0]        pressure_raw,
  input  logic [23:0]        temp_raw,
  input  logic               pop,
  output logic               empty,
  output logic signed [18:0] temp_centi,
  output logic signed [17:0] pressure_mbar,
  output logic               pressure_saturated,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data
);
  localparam int PW = $clog2(OUT_DEPTH + 1);

  ptc_pkg::cfg_t    cfg;
  ptc_pkg::item_t   item;
  ptc_pkg::result_t res;
  logic             avail;
  logic             issue;
  logic             res_valid;
  logic             out_full;
  logic             out_pop;
  logic [PW-1:0]    pend;
  logic [$bits(ptc_pkg::result_t)-1:0] out_dout;
  ptc_pkg::result_t out_res;

  // Calibration registers; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (ptc_pkg::reg_idx_t'(wr_index))
        ptc_pkg::REG_MODEL:    cfg.sensor_model  <= wr_data[0];
        ptc_pkg::REG_SENS:     cfg.coef_sens     <= wr_data;
        ptc_pkg::REG_OFF:      cfg.coef_off      <= wr_data;
        ptc_pkg::REG_TCS:      cfg.coef_tcs      <= wr_data;
        ptc_pkg::REG_TCO:      cfg.coef_tco      <= wr_data;
        ptc_pkg::REG_TREF:     cfg.coef_tref     <= wr_data;
        ptc_pkg::REG_TEMPSENS: cfg.coef_tempsens <= wr_data;
        default: ;
      endcase
    end
  end

  ptc_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pressure_raw(pressure_raw),
    .temp_raw    (temp_raw),
    .full        (full),
    .cfg         (cfg),
    .issue       (issue),
    .avail       (avail),
    .item        (item)
  );

  // pend counts items in the pipeline plus items in the result queue;
  // issue only while a result slot is guaranteed.
  assign out_pop = pop && !empty;
  assign issue   = avail && (pend < PW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (issue && !out_pop) begin
      pend <= pend + 1'b1;
    end else if (out_pop && !issue) begin
      pend <= pend - 1'b1;
    end
  end

  ptc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .item     (item),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  ptc_fifo #(
    .WIDTH($bits(ptc_pkg::result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .din  (res),
    .full (out_full),
    .pop  (pop),
    .dout (out_dout),
    .empty(empty)
  );

  assign out_res            = ptc_pkg::result_t'(out_dout);
  assign temp_centi         = out_res.temp_centi;
  assign pressure_mbar      = out_res.pressure_mbar;
  assign pressure_saturated = out_res.pressure_saturated;

  `PTC_ASSERT_HOLDS(a_out_room, clk, rst, res_valid, !out_full)
  `PTC_ASSERT_HOLDS(a_pend_empty, clk, rst, pend == '0, empty)
  `PTC_ASSERT_NEXT(a_pend_step, clk, rst, issue && !out_pop, pend == $past(pend) + 1'b1)

endmodule

// ----- test/pressure_temp_compensation_chk.sv -----
// ----------------------------------------------------------------------------
// pressure_temp_compensation_chk
// Watches the input, result and register channels of the compensation block,
// predicts each result from the raw pair and the current calibration and
// compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [23:0]        pressure_raw,
  input  logic [23:0]        temp_raw,
  input  logic               pop,
  input  logic               empty,
  input  logic signed [18:0] temp_centi,
  input  logic signed [17:0] pressure_mbar,
  input  logic               pressure_saturated,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  ptc_pkg::cfg_t    calib;
  ptc_pkg::result_t readings_q[$];

  function automatic longint widen(input logic [23:0] v);
    return longint'({40'b0, v});
  endfunction

  function automatic longint widen16(input logic [15:0] v);
    return longint'({48'b0, v});
  endfunction

  // Two-stage compensation at 64-bit width; SV signed division truncates
  // toward zero.
  function automatic ptc_pkg::result_t compensate(input logic [23:0] d1u,
                                                  input logic [23:0] d2u,
                                                  input ptc_pkg::cfg_t c);
    longint d1, dt, temp, off, sens, ti, offi, sensi, dev, dev2, v, p;
    ptc_pkg::result_t r;
    d1   = widen(d1u);
    dt   = widen(d2u) - widen16(c.coef_tref) * 256;
    temp = 2000 + (dt * widen16(c.coef_tempsens)) / 64'sd8388608;
    if (c.sensor_model) begin
      sens = widen16(c.coef_sens) * 65536 + (widen16(c.coef_tcs) * dt) / 128;
      off  = widen16(c.coef_off) * 131072 + (widen16(c.coef_tco) * dt) / 64;
    end else begin
      sens = widen16(c.coef_sens) * 32768 + (widen16(c.coef_tcs) * dt) / 256;
      off  = widen16(c.coef_off) * 65536 + (widen16(c.coef_tco) * dt) / 128;
    end
    dev   = temp - 2000;
    dev2  = dev * dev;
    ti    = 0;
    offi  = 0;
    sensi = 0;
    if (c.sensor_model) begin
      if (temp < 2000) begin
        ti    = (11 * dt * dt) / 64'sd34359738368;
        offi  = (31 * dev2) / 8;
        sensi = (63 * dev2) / 32;
      end
    end else if (temp < 2000) begin
      ti    = (3 * dt * dt) / 64'sd8589934592;
      offi  = (3 * dev2) / 2;
      sensi = (5 * dev2) / 8;
      if (temp < -1500) begin
        v     = temp + 1500;
        offi  = offi + 7 * v * v;
        sensi = sensi + 4 * v * v;
      end
    end else begin
      ti    = (2 * dt * dt) / 64'sd137438953472;
      offi  = dev2 / 16;
    end
    off  = off - offi;
    sens = sens - sensi;
    temp = temp - ti;
    if (c.sensor_model) p = (((d1 * sens) / 2097152 - off) / 32768) / 100;
    else                p = (((d1 * sens) / 2097152 - off) / 8192) / 10;
    r.pressure_saturated = 1'b0;
    if (p > 131071) begin
      p = 131071;
      r.pressure_saturated = 1'b1;
    end else if (p < -131072) begin
      p = -131072;
      r.pressure_saturated = 1'b1;
    end
    r.temp_centi    = temp[18:0];
    r.pressure_mbar = p[17:0];
    return r;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    clipped = 0;
  end

  always @(posedge clk) begin
    ptc_pkg::result_t want;
    if (rst) begin
      calib = '0;
      readings_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          ptc_pkg::REG_MODEL:    calib.sensor_model  = wr_data[0];
          ptc_pkg::REG_SENS:     calib.coef_sens     = wr_data;
          ptc_pkg::REG_OFF:      calib.coef_off      = wr_data;
          ptc_pkg::REG_TCS:      calib.coef_tcs      = wr_data;
          ptc_pkg::REG_TCO:      calib.coef_tco      = wr_data;
          ptc_pkg::REG_TREF:     calib.coef_tref     = wr_data;
          ptc_pkg::REG_TEMPSENS: calib.coef_tempsens = wr_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (readings_q.size() == 0) begin
          report("unexpected result", longint'(pressure_mbar), longint'(0));
        end else begin
          want = readings_q.pop_front();
          checked++;
          if (want.pressure_saturated) clipped++;
          if (temp_centi !== want.temp_centi)
            report("temp_centi", longint'(temp_centi), longint'(want.temp_centi));
          if (pressure_mbar !== want.pressure_mbar)
            report("pressure_mbar", longint'(pressure_mbar),
                   longint'(want.pressure_mbar));
          if (pressure_saturated !== want.pressure_saturated)
            report("pressure_saturated", longint'(pressure_saturated),
                   longint'(want.pressure_saturated));
        end
      end
      if (push && !full)
        readings_q.push_back(compensate(pressure_raw, temp_raw, calib));
    end
    pending = readings_q.size();
  end

endmodule

// ----- test/pressure_temp_compensation_tb.sv -----
// ----------------------------------------------------------------------------
// pressure_temp_compensation_tb
// Drives raw pressure/temperature pairs and calibration settings into the
// compensation block; a checker beside it predicts and compares each result.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index beyond the register list; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // Cycles with no accepted item on either side before giving up.
  localparam int QUIET_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [23:0]        pressure_raw = '0;
  logic [23:0]        temp_raw = '0;
  logic               pop = 1'b0;
  logic               empty;
  logic signed [18:0] temp_centi;
  logic signed [17:0] pressure_mbar;
  logic               pressure_saturated;
  logic               wr_en = 1'b0;
  logic [2:0]         wr_index = '0;
  logic [15:0]        wr_data = '0;

  int            errors, pending, checked, clipped;
  int            quiet = 0;
  int            sent = 0;
  bit            no_idle = 1'b0;
  ptc_pkg::cfg_t shadow;

  pressure_temp_compensation u_dut (
    .clk, .rst, .push, .full, .pressure_raw, .temp_raw,
    .pop, .empty, .temp_centi, .pressure_mbar, .pressure_saturated,
    .wr_en, .wr_index, .wr_data
  );

  pressure_temp_compensation_chk u_chk (
    .clk, .rst, .push, .full, .pressure_raw, .temp_raw,
    .pop, .empty, .temp_centi, .pressure_mbar, .pressure_saturated,
    .wr_en, .wr_index, .wr_data,
    .errors, .pending, .checked, .clipped
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: stall at random except during the no-idle stretch.
  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else     pop = no_idle || ($urandom_range(99) >= 22);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Write one register; entered and left at a falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(negedge clk);
    wr_en    = 1'b0;
  endtask

  task automatic load_calib(input ptc_pkg::cfg_t c);
    shadow = c;
    write_reg(ptc_pkg::REG_MODEL, {15'b0, c.sensor_model});
    write_reg(ptc_pkg::REG_SENS, c.coef_sens);
    write_reg(ptc_pkg::REG_OFF, c.coef_off);
    write_reg(ptc_pkg::REG_TCS, c.coef_tcs);
    write_reg(ptc_pkg::REG_TCO, c.coef_tco);
    write_reg(ptc_pkg::REG_TREF, c.coef_tref);
    write_reg(ptc_pkg::REG_TEMPSENS, c.coef_tempsens);
  endtask

  // Offer one item; hold push until the block takes it.
  task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2);
    while (!no_idle && $urandom_range(99) < 22) begin
      push = 1'b0;
      @(negedge clk);
    end
    push         = 1'b1;
    pressure_raw = d1;
    temp_raw     = d2;
    do @(posedge clk); while (full);
    @(negedge clk);
    sent++;
  endtask

  // Drop push and wait until every expected result has come back.
  task automatic drain;
    push = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Temperature reading placed around the reference point, so that warm,
  // cold and very cold bands all get hit.
  function automatic logic [23:0] near_tref(input ptc_pkg::cfg_t c);
    longint base, d;
    base = longint'(c.coef_tref) * 256;
    case ($urandom_range(3))
      0:       d = longint'($urandom_range(4000000)) - 2000000;
      1:       d = -longint'($urandom_range(9000000));
      2:       d = longint'($urandom_range(300000));
      default: d = longint'($urandom_range(16777215)) - base;
    endcase
    d = base + d;
    if (d < 0) d = 0;
    if (d > 16777215) d = 16777215;
    return d[23:0];
  endfunction

  function automatic ptc_pkg::cfg_t random_calib();
    ptc_pkg::cfg_t c;
    c.sensor_model = 1'($urandom_range(1));
    if ($urandom_range(1)) begin
      // Typical factory words with some spread.
      c.coef_sens     = 16'(30000 + $urandom_range(10000));
      c.coef_off      = 16'(30000 + $urandom_range(10000));
      c.coef_tcs      = 16'(15000 + $urandom_range(10000));
      c.coef_tco      = 16'(15000 + $urandom_range(10000));
      c.coef_tref     = 16'(22000 + $urandom_range(10000));
      c.coef_tempsens = 16'(22000 + $urandom_range(10000));
    end else begin
      c.coef_sens     = 16'($urandom_range(65535));
      c.coef_off      = 16'($urandom_range(65535));
      c.coef_tcs      = 16'($urandom_range(65535));
      c.coef_tco      = 16'($urandom_range(65535));
      c.coef_tref     = 16'($urandom_range(65535));
      c.coef_tempsens = 16'($urandom_range(65535));
    end
    return c;
  endfunction

  initial begin
    ptc_pkg::cfg_t c;
    shadow = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset calibration, all coefficients zero.
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    drain;

    // Saturate both ways: maximal sensitivity and offset, tref zero.
    c = '{sensor_model: 1'b0, coef_sens: 16'hFFFF, coef_off: 16'hFFFF,
          coef_tcs: 16'hFFFF, coef_tco: 16'hFFFF, coef_tref: 16'h0000,
          coef_tempsens: 16'hFFFF};
    load_calib(c);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'h000000, 24'h000000);
    drain;

    // All ones, then the same in 2 bar mode.
    c.coef_tref = 16'hFFFF;
    load_calib(c);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'h000000);
    drain;
    c.sensor_model = 1'b1;
    load_calib(c);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'h800000, 24'h7FFFFF);
    drain;

    // Typical factory words: warm, cold and very cold in both modes.
    c = '{sensor_model: 1'b0, coef_sens: 16'd34982, coef_off: 16'd36352,
          coef_tcs: 16'd20328, coef_tco: 16'd22354, coef_tref: 16'd26646,
          coef_tempsens: 16'd26146};
    load_calib(c);
    // Junk to a nonexistent index must leave the calibration alone.
    write_reg(REG_UNUSED, 16'hFFFF);
    send_pair(24'd4958179, 24'd6815414);
    send_pair(24'd4958179, 24'd6821376);
    send_pair(24'd4958179, 24'd5400000);
    send_pair(24'd4958179, 24'd2000000);
    send_pair(24'd4958179, 24'd0);
    drain;
    c.sensor_model = 1'b1;
    load_calib(c);
    send_pair(24'd4958179, 24'd6815414);
    send_pair(24'd4958179, 24'd9000000);
    send_pair(24'd4958179, 24'd2000000);
    send_pair(24'd0, 24'd0);
    drain;

    // Random phases; the third runs without any idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      c = random_calib();
      load_calib(c);
      no_idle = (ph == 2);
      for (int k = 0; k < 72; k++) begin
        if ($urandom_range(9) < 8) send_pair(24'($urandom_range(16777215)),
                                             near_tref(shadow));
        else                       send_pair(24'($urandom_range(16777215)),
                                             24'($urandom_range(16777215)));
      end
      drain;
      no_idle = 1'b0;
    end

    repeat (20) @(negedge clk);
    $display("sent %0d raw pairs over 12 calibration settings; %0d results checked",
             sent, checked);
    $display("%0d results had clipped pressure", clipped);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
